[design/irps_pkg.sv]
// types, constants and helpers for the ir pulse distance sender
// no dependencies; used by ir_pulse_distance_sender_unit
package irps_pkg;

  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned BIT_IDX_W  = $clog2(FRAME_BITS);
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned REP_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DUR_W-1:0] LEADER_MARK_RST  = DUR_W'(9000);
  localparam logic [DUR_W-1:0] LEADER_SPACE_RST = DUR_W'(4500);
  localparam logic [DUR_W-1:0] BIT_MARK_RST     = DUR_W'(560);
  localparam logic [DUR_W-1:0] ONE_SPACE_RST    = DUR_W'(1960);
  localparam logic [DUR_W-1:0] ZERO_SPACE_RST   = DUR_W'(560);
  localparam logic [REP_W-1:0] FRAME_REPEATS_RST = REP_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEADER_MARK   = 3'd0,
    CFG_LEADER_SPACE  = 3'd1,
    CFG_BIT_MARK      = 3'd2,
    CFG_ONE_SPACE     = 3'd3,
    CFG_ZERO_SPACE    = 3'd4,
    CFG_FRAME_REPEATS = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_TRAIL_MARK = 3'd5
  } phase_e;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SEND = 1'b1
  } req_type_e;

  typedef struct packed {
    logic       req_type;
    logic [4:0] player_id;
    logic [4:0] command_value;
  } req_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic sequence_done;
    logic request_dropped;
  } res_t;

  function automatic logic led_level(input phase_e ph);
    logic lvl;
    lvl = (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) || (ph == PH_TRAIL_MARK);
    return lvl;
  endfunction

  function automatic logic [FRAME_BITS-1:0] pack_frame(input logic [4:0] pid,
                                                       input logic [4:0] cmd);
    logic [15:0] w;
    w = {pid ^ cmd, cmd, pid, 1'b1};
    return FRAME_BITS'(w);
  endfunction

endpackage

[design/ir_pulse_distance_sender_unit.sv]
// a result beat appears in the cycle after its request beat is accepted
// throughput: one beat per cycle unless stalled; output register frees as read
// the phase fsm and duration counter update only on accepted beats
// reset: async active low; config/state regs load defaults, fsm returns to idle
// top level of the ir pulse distance sender; depends on irps_pkg
module ir_pulse_distance_sender_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [irps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  irps_pkg::req_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output irps_pkg::res_t                 out_data_o
);

  logic [irps_pkg::DUR_W-1:0] leader_mark_q, leader_space_q, bit_mark_q;
  logic [irps_pkg::DUR_W-1:0] one_space_q, zero_space_q;
  logic [irps_pkg::REP_W-1:0] frame_repeats_q;

  irps_pkg::phase_e                 phase_q, phase_d;
  logic [irps_pkg::FRAME_BITS-1:0]  frame_word_q, frame_word_d;
  logic [irps_pkg::BIT_IDX_W-1:0]   bit_index_q, bit_index_d;
  logic [irps_pkg::DUR_W-1:0]       duration_q, duration_d;
  logic [irps_pkg::REP_W-1:0]       repeats_q, repeats_d;
  logic [irps_pkg::BIT_IDX_W:0]     next_bit;
  logic [irps_pkg::REP_W-1:0]       repeats_inc;
  logic                             seq_done;

  logic           out_valid_q;
  irps_pkg::res_t out_data_q, res_d;
  logic           in_acc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_mark_q   <= irps_pkg::LEADER_MARK_RST;
      leader_space_q  <= irps_pkg::LEADER_SPACE_RST;
      bit_mark_q      <= irps_pkg::BIT_MARK_RST;
      one_space_q     <= irps_pkg::ONE_SPACE_RST;
      zero_space_q    <= irps_pkg::ZERO_SPACE_RST;
      frame_repeats_q <= irps_pkg::FRAME_REPEATS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        irps_pkg::CFG_LEADER_MARK:   leader_mark_q   <= cfg_wdata_i;
        irps_pkg::CFG_LEADER_SPACE:  leader_space_q  <= cfg_wdata_i;
        irps_pkg::CFG_BIT_MARK:      bit_mark_q      <= cfg_wdata_i;
        irps_pkg::CFG_ONE_SPACE:     one_space_q     <= cfg_wdata_i;
        irps_pkg::CFG_ZERO_SPACE:    zero_space_q    <= cfg_wdata_i;
        irps_pkg::CFG_FRAME_REPEATS: frame_repeats_q <= cfg_wdata_i[irps_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  assign next_bit    = {1'b0, bit_index_q} + 1'b1;
  assign repeats_inc = repeats_q + 1'b1;

  // next state
  always_comb begin
    phase_d      = phase_q;
    frame_word_d = frame_word_q;
    bit_index_d  = bit_index_q;
    duration_d   = duration_q;
    repeats_d    = repeats_q;
    seq_done     = 1'b0;
    if (in_acc) begin
      if (in_data_i.req_type == irps_pkg::REQ_SEND) begin
        if (phase_q == irps_pkg::PH_IDLE) begin
          frame_word_d = irps_pkg::pack_frame(in_data_i.player_id, in_data_i.command_value);
          phase_d      = irps_pkg::PH_LEAD_MARK;
          bit_index_d  = '0;
          repeats_d    = '0;
          duration_d   = leader_mark_q;
        end
      end else if (phase_q != irps_pkg::PH_IDLE) begin
        if (duration_q <= irps_pkg::DUR_W'(1)) begin
          unique case (phase_q)
            irps_pkg::PH_LEAD_MARK: begin
              phase_d    = irps_pkg::PH_LEAD_SPACE;
              duration_d = leader_space_q;
            end
            irps_pkg::PH_LEAD_SPACE: begin
              phase_d     = irps_pkg::PH_BIT_MARK;
              bit_index_d = irps_pkg::BIT_IDX_W'(1);
              duration_d  = bit_mark_q;
            end
            irps_pkg::PH_BIT_MARK: begin
              phase_d    = irps_pkg::PH_BIT_SPACE;
              duration_d = frame_word_q[bit_index_q] ? one_space_q : zero_space_q;
            end
            irps_pkg::PH_BIT_SPACE: begin
              if (next_bit < (irps_pkg::BIT_IDX_W+1)'(irps_pkg::FRAME_BITS)) begin
                bit_index_d = next_bit[irps_pkg::BIT_IDX_W-1:0];
                phase_d     = irps_pkg::PH_BIT_MARK;
              end else begin
                phase_d = irps_pkg::PH_TRAIL_MARK;
              end
              duration_d = bit_mark_q;
            end
            irps_pkg::PH_TRAIL_MARK: begin
              repeats_d = repeats_inc;
              if (repeats_inc >= frame_repeats_q || frame_repeats_q == '0) begin
                phase_d    = irps_pkg::PH_IDLE;
                duration_d = '0;
                seq_done   = 1'b1;
              end else begin
                phase_d     = irps_pkg::PH_LEAD_MARK;
                bit_index_d = '0;
                duration_d  = leader_mark_q;
              end
            end
            default: begin
              phase_d    = irps_pkg::PH_IDLE;
              duration_d = '0;
            end
          endcase
        end else begin
          duration_d = duration_q - 1'b1;
        end
      end
    end
  end

  // result beat
  always_comb begin
    res_d = '0;
    if (in_data_i.req_type == irps_pkg::REQ_SEND) begin
      res_d.request_dropped = (phase_q != irps_pkg::PH_IDLE);
      res_d.led_on          = irps_pkg::led_level(phase_d);
      res_d.busy_res        = (phase_d != irps_pkg::PH_IDLE);
    end else if (phase_q != irps_pkg::PH_IDLE) begin
      res_d.led_on        = irps_pkg::led_level(phase_q);
      res_d.busy_res      = 1'b1;
      res_d.sequence_done = seq_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= irps_pkg::PH_IDLE;
      bit_index_q <= '0;
      duration_q  <= '0;
      repeats_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bit_index_q <= bit_index_d;
      duration_q  <= duration_d;
      repeats_q   <= repeats_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_word_q <= frame_word_d;
    if (in_acc) begin
      out_data_q <= res_d;
    end
  end

endmodule
